FILE: src/r2e_pkg.sv
`default_nettype none
package r2e_pkg;

  // cordic datapath, independent of the element width since operands are prescaled to 2^40
  localparam int CORDIC_W = 44;
  localparam int ANG_W = 20;
  localparam int CORDIC_STEPS = 16;

  localparam int LANES = 5;
  localparam int LANE_P0 = 0;
  localparam int LANE_P1 = 1;
  localparam int LANE_YAW = 2;
  localparam int LANE_R0 = 3;
  localparam int LANE_R1 = 4;

  localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [ANG_W-1:0] PI_Q16 = 20'sd205887;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [ANG_W-1:0]    z;
  } lane_t;

  function automatic logic signed [ANG_W-1:0] atan_entry(input int step);
    logic signed [ANG_W-1:0] a;
    unique case (step)
      0:       a = 20'sd51472;
      1:       a = 20'sd30386;
      2:       a = 20'sd16055;
      3:       a = 20'sd8150;
      4:       a = 20'sd4091;
      5:       a = 20'sd2047;
      6:       a = 20'sd1024;
      7:       a = 20'sd512;
      8:       a = 20'sd256;
      9:       a = 20'sd128;
      10:      a = 20'sd64;
      11:      a = 20'sd32;
      12:      a = 20'sd16;
      13:      a = 20'sd8;
      14:      a = 20'sd4;
      15:      a = 20'sd2;
      default: a = '0;
    endcase
    return a;
  endfunction

  // quarter turn so that x is non-negative before the micro-rotations
  function automatic lane_t lane_prerotate(input lane_t v);
    lane_t r;
    r = v;
    if (v.x[CORDIC_W-1]) begin
      if (!v.y[CORDIC_W-1]) begin
        r.y = -v.x;
        r.x = v.y;
        r.z = HALF_PI_Q16;
      end else begin
        r.y = v.x;
        r.x = -v.y;
        r.z = -HALF_PI_Q16;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/r2e_sqrt_cell.sv
`default_nettype none
module r2e_sqrt_cell #(
  parameter int W = 29,
  parameter int BIT_POS = 28
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d_n,
  input  logic [W-1:0] d_r,
  output logic [W-1:0] q_n,
  output logic [W-1:0] q_r
);

  localparam logic [W-1:0] BIT_VAL = W'(1) << BIT_POS;

  logic [W-1:0] trial;
  logic [W-1:0] q_n_next;
  logic [W-1:0] q_r_next;

  always_comb begin
    trial = d_r + BIT_VAL;
    if (d_n >= trial) begin
      q_n_next = d_n - trial;
      q_r_next = (d_r >> 1) + BIT_VAL;
    end else begin
      q_n_next = d_n;
      q_r_next = d_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_n <= q_n_next;
      q_r <= q_r_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/r2e_cordic_cell.sv
`default_nettype none
module r2e_cordic_cell
  import r2e_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic  clk,
  input  logic  en,
  input  lane_t d,
  output lane_t q
);

  localparam logic signed [ANG_W-1:0] ATAN = atan_entry(STEP);

  logic signed [CORDIC_W-1:0] xs;
  logic signed [CORDIC_W-1:0] ys;
  lane_t q_next;

  always_comb begin
    xs = d.x >>> STEP;
    ys = d.y >>> STEP;
    q_next = d;
    // a lane whose y reached zero has converged and just passes on
    if (d.y != '0) begin
      if (!d.y[CORDIC_W-1]) begin
        q_next.x = d.x + ys;
        q_next.y = d.y - xs;
        q_next.z = d.z + ATAN;
      end else begin
        q_next.x = d.x - ys;
        q_next.y = d.y + xs;
        q_next.z = d.z - ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/rotation_matrix_to_euler_angles.sv
// throughput: one item per cycle while the output is not stalled; the whole pipeline advances together
// pipeline: input reg, prep, square, ELEMENT_WIDTH-1 square root cells, cordic prerotate,
//   16 cordic cells in five lanes, rounding, solution select / output reg
// a stalled output freezes every stage; rst clears the valid line and sets threshold to 16
`default_nettype none
module rotation_matrix_to_euler_angles
  import r2e_pkg::*;
#(
  parameter int ELEMENT_WIDTH = 16,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic        cfg_we,
  input  logic [13:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // m00, m01, m02, m10, m12, m20, m21, m22
  input  logic [8*ELEMENT_WIDTH-1:0] s_tdata,
  // left_handed
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // pitch, yaw, roll
  output logic [((3*ANGLE_WIDTH+7)/8)*8-1:0] m_tdata,
  // gimbal_lock
  output logic [0:0]  m_tuser
);

  localparam int EW = ELEMENT_WIDTH;
  localparam int AW = ANGLE_WIDTH;
  localparam int FE = EW - 2;
  localparam int FA = AW - 4;
  localparam int PRESCALE = 40 - EW;
  localparam int NW = 2 * FE + 1;
  localparam int NSTG = 3 + (FE + 1) + 1 + CORDIC_STEPS + 2;
  localparam int OUT_DW = ((3 * AW + 7) / 8) * 8;
  localparam int RND_SH = (FA < 16) ? 16 - FA : 0;
  localparam int RND_BIT = (RND_SH > 0) ? RND_SH - 1 : 0;
  localparam int UP_SH = (FA < 16) ? 0 : FA - 16;
  localparam logic signed [47:0] OUT_HI = (48'sd1 <<< (AW - 1)) - 48'sd1;
  localparam logic signed [47:0] OUT_LO = -(48'sd1 <<< (AW - 1));
  localparam logic signed [EW+1:0] ONE = (EW + 2)'(1) << FE;
  localparam logic signed [EW-1:0] ONE_S = EW'(1) << FE;
  localparam logic [NW-1:0] ONE_SQ = {1'b1, {(2 * FE){1'b0}}};

  typedef struct packed {
    logic signed [EW:0] p0y;
    logic signed [EW:0] p0x;
    logic signed [EW:0] p1y;
    logic signed [EW:0] p1x;
    logic signed [EW:0] r0y;
    logic signed [EW:0] r0x;
    logic signed [EW:0] r1y;
    logic signed [EW:0] r1x;
    logic signed [EW-1:0] s;
    logic lock;
    logic lock_n;
  } side_t;

  typedef struct packed {
    logic lock;
    logic lock_n;
  } flag_t;

  function automatic logic signed [AW-1:0] to_out(input logic signed [ANG_W-1:0] z);
    logic signed [47:0] w;
    logic signed [47:0] v;
    w = {{(48 - ANG_W){z[ANG_W-1]}}, z};
    if (FA < 16) begin
      v = (w + (48'sd1 <<< RND_BIT)) >>> RND_SH;
    end else begin
      v = w <<< UP_SH;
    end
    if (v > OUT_HI) v = OUT_HI;
    if (v < OUT_LO) v = OUT_LO;
    return v[AW-1:0];
  endfunction

  function automatic logic [AW+1:0] abs_ext(input logic signed [AW-1:0] v);
    logic signed [AW+1:0] e;
    e = {{2{v[AW-1]}}, v};
    return e[AW+1] ? -e : e;
  endfunction

  function automatic logic signed [CORDIC_W-1:0] op_ext(input logic signed [EW:0] v);
    logic signed [CORDIC_W-1:0] e;
    e = {{(CORDIC_W - EW - 1){v[EW]}}, v};
    return e <<< PRESCALE;
  endfunction

  function automatic logic signed [EW:0] neg_ext(input logic signed [EW-1:0] v);
    return -{v[EW-1], v};
  endfunction

  function automatic logic signed [EW:0] pos_ext(input logic signed [EW-1:0] v);
    return {v[EW-1], v};
  endfunction

  logic en;
  logic [NSTG-1:0] vld;
  logic [13:0] thr;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= 14'd16;
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], s_tvalid};
    end
  end

  // input register
  logic signed [EW-1:0] in_m [0:7];
  logic in_lh;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 8; k++) begin
        in_m[k] <= s_tdata[k*EW +: EW];
      end
      in_lh <= s_tuser[0];
    end
  end

  // transpose when left_handed, lock detection, clamp and lane operands
  logic signed [EW-1:0] a00, a01, a02, a10, a12, a20, a22;
  logic signed [EW+1:0] dn, dp;
  logic [EW+1:0] adn, adp, thr_ext;
  logic lock_n, lock_p;
  side_t prep_next;
  side_t prep;

  always_comb begin
    a00 = in_m[0];
    a22 = in_m[7];
    if (in_lh) begin
      a01 = in_m[3];
      a02 = in_m[5];
      a10 = in_m[1];
      a12 = in_m[6];
      a20 = in_m[2];
    end else begin
      a01 = in_m[1];
      a02 = in_m[2];
      a10 = in_m[3];
      a12 = in_m[4];
      a20 = in_m[5];
    end
    dn = {{2{a02[EW-1]}}, a02} + ONE;
    dp = {{2{a02[EW-1]}}, a02} - ONE;
    adn = dn[EW+1] ? -dn : dn;
    adp = dp[EW+1] ? -dp : dp;
    thr_ext = (EW + 2)'(thr);
    lock_n = thr_ext > adn;
    lock_p = !lock_n && (thr_ext > adp);

    prep_next.lock = lock_n || lock_p;
    prep_next.lock_n = lock_n;
    if (lock_n) begin
      prep_next.p0y = pos_ext(a10);
      prep_next.p0x = pos_ext(a20);
    end else if (lock_p) begin
      prep_next.p0y = neg_ext(a10);
      prep_next.p0x = neg_ext(a20);
    end else begin
      prep_next.p0y = pos_ext(a12);
      prep_next.p0x = pos_ext(a22);
    end
    prep_next.p1y = neg_ext(a12);
    prep_next.p1x = neg_ext(a22);
    prep_next.r0y = pos_ext(a01);
    prep_next.r0x = pos_ext(a00);
    prep_next.r1y = neg_ext(a01);
    prep_next.r1x = neg_ext(a00);
    if (a02 > ONE_S) begin
      prep_next.s = ONE_S;
    end else if (a02 < -ONE_S) begin
      prep_next.s = -ONE_S;
    end else begin
      prep_next.s = a02;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep <= prep_next;
    end
  end

  // 1 - s^2 feeding the square root row
  logic signed [2*EW-1:0] sq;
  logic [NW-1:0] sq_n [0:FE+1];
  logic [NW-1:0] sq_r [0:FE+1];
  side_t side [0:FE+1];

  assign sq = prep.s * prep.s;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_n[0] <= ONE_SQ - sq[NW-1:0];
      side[0] <= prep;
    end
  end

  assign sq_r[0] = '0;

  for (genvar k = 0; k <= FE; k++) begin : g_sqrt
    r2e_sqrt_cell #(
      .W(NW),
      .BIT_POS(2 * (FE - k))
    ) u_cell (
      .clk(clk),
      .en(en),
      .d_n(sq_n[k]),
      .d_r(sq_r[k]),
      .q_n(sq_n[k+1]),
      .q_r(sq_r[k+1])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        side[k+1] <= side[k];
      end
    end
  end

  // cordic entry
  lane_t cl [0:CORDIC_STEPS][0:LANES-1];
  flag_t fl [0:CORDIC_STEPS];
  lane_t entry [0:LANES-1];
  side_t sd;
  logic signed [EW:0] cosv;

  always_comb begin
    sd = side[FE+1];
    cosv = {2'b00, sq_r[FE+1][FE:0]};
    entry[LANE_P0] = '{x: op_ext(sd.p0x), y: op_ext(sd.p0y), z: '0};
    entry[LANE_P1] = '{x: op_ext(sd.p1x), y: op_ext(sd.p1y), z: '0};
    entry[LANE_YAW] = '{x: op_ext(cosv), y: op_ext(pos_ext(sd.s)), z: '0};
    entry[LANE_R0] = '{x: op_ext(sd.r0x), y: op_ext(sd.r0y), z: '0};
    entry[LANE_R1] = '{x: op_ext(sd.r1x), y: op_ext(sd.r1y), z: '0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        cl[0][l] <= lane_prerotate(entry[l]);
      end
      fl[0] <= '{lock: sd.lock, lock_n: sd.lock_n};
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      r2e_cordic_cell #(
        .STEP(k)
      ) u_cell (
        .clk(clk),
        .en(en),
        .d(cl[k][l]),
        .q(cl[k+1][l])
      );
    end

    always_ff @(posedge clk) begin
      if (en) begin
        fl[k+1] <= fl[k];
      end
    end
  end

  // rounding to output format
  logic signed [AW-1:0] p0, p1, y0, y1, r0, r1;
  logic f_lock;
  flag_t fe;
  logic signed [ANG_W-1:0] zy;

  assign fe = fl[CORDIC_STEPS];
  assign zy = cl[CORDIC_STEPS][LANE_YAW].z;

  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= to_out(cl[CORDIC_STEPS][LANE_P0].z);
      p1 <= to_out(cl[CORDIC_STEPS][LANE_P1].z);
      r1 <= to_out(cl[CORDIC_STEPS][LANE_R1].z);
      y1 <= to_out(PI_Q16 + zy);
      f_lock <= fe.lock;
      if (fe.lock) begin
        y0 <= fe.lock_n ? to_out(HALF_PI_Q16) : to_out(-HALF_PI_Q16);
        r0 <= '0;
      end else begin
        y0 <= to_out(-zy);
        r0 <= to_out(cl[CORDIC_STEPS][LANE_R0].z);
      end
    end
  end

  // pick the solution with the smaller angle sum; solution 0 on a tie or under gimbal lock
  logic [AW+3:0] sum0, sum1;
  logic pick1;
  logic signed [AW-1:0] out_pitch, out_yaw, out_roll;
  logic out_lock;

  always_comb begin
    sum0 = (AW + 4)'(abs_ext(p0)) + (AW + 4)'(abs_ext(y0)) + (AW + 4)'(abs_ext(r0));
    sum1 = (AW + 4)'(abs_ext(p1)) + (AW + 4)'(abs_ext(y1)) + (AW + 4)'(abs_ext(r1));
    pick1 = !f_lock && (sum0 > sum1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pitch <= pick1 ? p1 : p0;
      out_yaw <= pick1 ? y1 : y0;
      out_roll <= pick1 ? r1 : r0;
      out_lock <= f_lock;
    end
  end

  assign m_tdata = OUT_DW'({out_roll, out_yaw, out_pitch});
  assign m_tuser[0] = out_lock;

`ifndef SYNTHESIS
  localparam logic signed [AW-1:0] YAW_LOCK_P = to_out(HALF_PI_Q16);
  localparam logic signed [AW-1:0] YAW_LOCK_N = to_out(-HALF_PI_Q16);

  a_lock_roll_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_lock |-> out_roll == '0)
    else $error("gimbal lock result with nonzero roll");

  a_lock_yaw: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_lock |-> (out_yaw == YAW_LOCK_P || out_yaw == YAW_LOCK_N))
    else $error("gimbal lock result with yaw not at a quarter turn");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> vld == $past(vld))
    else $error("valid line moved during stall");

  a_thr_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> thr == 14'd16)
    else $error("threshold not at reset value");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_rotation_matrix_to_euler_angles.sv
`timescale 1ns / 1ps
`default_nettype none

class euler_scoreboard;
  typedef struct packed {
    logic [15:0] pitch;
    logic [15:0] yaw;
    logic [15:0] roll;
    logic        lock;
  } angles_t;

  angles_t pending_angles[$];
  int unsigned mismatches;
  int unsigned unexpected;
  logic [13:0] lock_thr;

  function new();
    mismatches = 0;
    unexpected = 0;
    lock_thr = 14'd16;
  endfunction

  static function longint asr(longint v, int s);
    return v >>> s;
  endfunction

  static function longint atan2_q16(longint ya, longint xa);
    longint x, y, z, t, xs, ys;
    longint tab[16];
    tab = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
            256, 128, 64, 32, 16, 8, 4, 2};
    y = ya <<< 24;
    x = xa <<< 24;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = y; y = -x; x = t; z = 102944;
      end else begin
        t = -y; y = x; x = t; z = -102944;
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (y == 0) break;
      xs = asr(x, i);
      ys = asr(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += tab[i];
      end else begin
        x -= ys; y += xs; z -= tab[i];
      end
    end
    return z;
  endfunction

  static function longint round_angle(longint z);
    longint v;
    v = (z + 8) >>> 4;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  static function longint floor_sqrt(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  static function longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function void note_matrix(logic [127:0] elems, logic lh);
    longint e[8];
    longint a00, a01, a02, a10, a12, a20, a22, s, c, y0q, thr;
    longint p, yw, r, p0, p1, y0, y1, r0, r1;
    angles_t exp_a;
    for (int i = 0; i < 8; i++) e[i] = longint'($signed(elems[16*i +: 16]));
    a00 = e[0]; a01 = e[1]; a02 = e[2]; a10 = e[3];
    a12 = e[4]; a20 = e[5]; a22 = e[7];
    if (lh) begin
      a01 = e[3]; a02 = e[5]; a10 = e[1]; a12 = e[6]; a20 = e[2];
    end
    thr = lock_thr;
    exp_a.lock = 1'b1;
    if (thr > mag(a02 + 16384)) begin
      r = 0;
      yw = round_angle(102944);
      p = round_angle(atan2_q16(a10, a20));
    end else if (thr > mag(a02 - 16384)) begin
      r = 0;
      yw = round_angle(-102944);
      p = round_angle(atan2_q16(-a10, -a20));
    end else begin
      exp_a.lock = 1'b0;
      s = a02;
      if (s > 16384) s = 16384;
      if (s < -16384) s = -16384;
      c = floor_sqrt(16384 * 16384 - s * s);
      y0q = -atan2_q16(s, c);
      y0 = round_angle(y0q);
      y1 = round_angle(205887 - y0q);
      p0 = round_angle(atan2_q16(a12, a22));
      p1 = round_angle(atan2_q16(-a12, -a22));
      r0 = round_angle(atan2_q16(a01, a00));
      r1 = round_angle(atan2_q16(-a01, -a00));
      if (mag(p0) + mag(y0) + mag(r0) > mag(p1) + mag(y1) + mag(r1)) begin
        p = p1; yw = y1; r = r1;
      end else begin
        p = p0; yw = y0; r = r0;
      end
    end
    exp_a.pitch = p[15:0];
    exp_a.yaw = yw[15:0];
    exp_a.roll = r[15:0];
    pending_angles.push_back(exp_a);
  endfunction

  function void check_angles(logic [47:0] data, logic lock);
    angles_t exp_a;
    if (pending_angles.size() == 0) begin
      unexpected++;
      if (mismatches + unexpected <= 10)
        $display("unexpected result data=%h lock=%b", data, lock);
      return;
    end
    exp_a = pending_angles.pop_front();
    if (data[15:0] !== exp_a.pitch || data[31:16] !== exp_a.yaw ||
        data[47:32] !== exp_a.roll || lock !== exp_a.lock) begin
      mismatches++;
      if (mismatches + unexpected <= 10)
        $display("mismatch: exp p=%h y=%h r=%h g=%b  got p=%h y=%h r=%h g=%b",
                 exp_a.pitch, exp_a.yaw, exp_a.roll, exp_a.lock,
                 data[15:0], data[31:16], data[47:32], lock);
    end
  endfunction
endclass

module tb_rotation_matrix_to_euler_angles;
  import r2e_pkg::*;

  localparam int ONE = 16384;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [13:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [127:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [0:0] m_tuser;

  euler_scoreboard sb = new();
  longint cycle_count = 0;
  bit long_hold = 1'b0;
  bit rx_bursty = 1'b1;

  rotation_matrix_to_euler_angles u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) sb.check_angles(m_tdata, m_tuser[0]);
  end

  // receiver stall pattern, with a long hold-off when requested
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (long_hold) m_tready <= 1'b0;
    else if (!rx_bursty) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  task automatic send_matrix(logic [127:0] elems, logic lh);
    s_tdata <= elems;
    s_tuser <= lh;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_matrix(elems, lh);
    @(negedge clk);
  endtask

  task automatic idle_sender(int n);
    s_tvalid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sb.pending_angles.size() != 0) @(negedge clk);
    repeat (45) @(negedge clk);
  endtask

  task automatic write_threshold(logic [13:0] v);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.lock_thr = v;
  endtask

  function automatic logic [15:0] rnd_elem();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 2 * ONE) - ONE);
      2: return 16'(ONE - $urandom_range(0, 40));
      3: return 16'(-ONE + $urandom_range(0, 40));
      4: return 16'($urandom_range(0, 8) - 4);
      default: return 16'($urandom_range(0, 800) - 400);
    endcase
  endfunction

  function automatic logic [127:0] rnd_matrix();
    logic [127:0] m;
    for (int i = 0; i < 8; i++) m[16*i +: 16] = rnd_elem();
    return m;
  endfunction

  function automatic logic [127:0] pack8(int a, int b, int c, int d, int e, int f,
                                         int g, int h);
    return {16'(h), 16'(g), 16'(f), 16'(e), 16'(d), 16'(c), 16'(b), 16'(a)};
  endfunction

  task automatic random_phase(int n);
    int left;
    left = n;
    while (left > 0) begin
      for (int k = $urandom_range(1, 20); k > 0 && left > 0; k--) begin
        send_matrix(rnd_matrix(), 1'($urandom_range(0, 1)));
        left--;
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 8));
    end
  endtask

  initial begin
    logic [13:0] thr_set[4];
    thr_set = '{14'd0, 14'd16383, 14'd200, 14'd1};
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: identity, extremes, gimbal lock both ways, clamp, zero operands
    send_matrix(pack8(ONE, 0, 0, 0, 0, 0, 0, ONE), 1'b0);
    send_matrix(pack8(0, 0, -ONE, ONE, 0, 0, 0, 0), 1'b0);
    send_matrix(pack8(0, 0, ONE, ONE, 0, ONE, 0, 0), 1'b0);
    send_matrix(pack8(0, 0, -ONE + 3, -200, 0, 300, 0, 0), 1'b0);
    send_matrix(pack8(0, 0, ONE - 3, 200, 0, -300, 0, 0), 1'b0);
    send_matrix(pack8(0, 0, 32767, 5, 7, 9, 0, -3), 1'b0);
    send_matrix(pack8(0, 0, -32768, 5, 7, 9, 0, -3), 1'b0);
    send_matrix(pack8(0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
    send_matrix(pack8(0, 0, 0, 0, 0, 0, 0, 0), 1'b1);
    send_matrix('1, 1'b1);
    send_matrix(pack8(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767), 1'b0);
    send_matrix(pack8(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768),
                1'b1);
    send_matrix(pack8(-ONE, 0, 0, 0, ONE, 0, 0, -ONE), 1'b0);
    send_matrix(pack8(ONE, 100, 500, -ONE, 20, ONE - 1, 1234, -77), 1'b1);
    send_matrix(pack8(-1, -1, 0, 0, -1, 0, 0, 1), 1'b0);
    send_matrix(pack8(0, 0, 9000, 0, 0, 0, 0, 0), 1'b0);
    random_phase(30);

    // long receiver hold-off while the sender keeps offering
    long_hold = 1'b1;
    fork
      random_phase(70);
      begin
        repeat (150) @(negedge clk);
        long_hold = 1'b0;
      end
    join
    drain_results();

    foreach (thr_set[i]) begin
      write_threshold(thr_set[i]);
      rx_bursty = (i % 2 == 0);
      random_phase(80);
      drain_results();
    end
    write_threshold(14'd16);
    random_phase(30);

    drain_results();
    if (sb.mismatches == 0 && sb.unexpected == 0 && sb.pending_angles.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule

`default_nettype wire

FILE: rotation_matrix_to_euler_angles.f
src/r2e_pkg.sv
src/r2e_sqrt_cell.sv
src/r2e_cordic_cell.sv
src/rotation_matrix_to_euler_angles.sv
tb/tb_rotation_matrix_to_euler_angles.sv
